[hw/rtl/sfc16_pkg.sv]
`timescale 1ns / 1ps

package sfc16_pkg;

	localparam int unsigned CountW = 9;
	localparam logic [CountW-1:0] CountMax = 9'h1FF;

	localparam logic [15:0] PolyReset = 16'h8408;
	localparam logic [7:0] SyncReset = 8'hFC;
	localparam logic [7:0] MinSizeReset = 8'd5;

	localparam logic [1:0] CfgPoly = 2'd0;
	localparam logic [1:0] CfgSync = 2'd1;
	localparam logic [1:0] CfgMinSize = 2'd2;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_TOO_SHORT = 3'd1,
		ST_BAD_SYNC = 3'd2,
		ST_BAD_LENGTH = 3'd3,
		ST_BAD_CRC = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0] status;
		logic [CountW-1:0] size;
		logic [15:0] computed_crc;
		logic [15:0] received_crc;
	} frame_result_t;

endpackage

[hw/rtl/serial_frame_crc16_checker_top.sv]
// Channel  | Direction | Handshake            | Payload
// input    | in        | in_valid / in_stall  | rx_byte, end_of_frame
// result   | out       | out_valid / out_stall| frame_status, frame_size, computed_crc,
//          |           |                      | received_crc
// config   | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte is taken every cycle unless in_stall is raised. A byte waits in the input register,
// and the frame state and the result register are updated when it advances, so a result is
// offered from the result register once the final byte has advanced out of the input register.
// The CRC update of the frame state has eight steps.
// Reset clears the frame state and loads the register defaults.
// A stalled result holds only bytes that end a frame; other bytes keep flowing.
`timescale 1ns / 1ps

module serial_frame_crc16_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_frame,
	input  logic        in_valid,
	output logic        in_stall,
	output logic [2:0]  frame_status,
	output logic [8:0]  frame_size,
	output logic [15:0] computed_crc,
	output logic [15:0] received_crc,
	output logic        out_valid,
	input  logic        out_stall,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] poly_q;
	logic [7:0] sync_q;
	logic [7:0] min_size_q;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic advance;
	logic accept;
	logic out_valid_q;
	sfc16_pkg::frame_result_t result;
	sfc16_pkg::frame_result_t result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= sfc16_pkg::PolyReset;
			sync_q <= sfc16_pkg::SyncReset;
			min_size_q <= sfc16_pkg::MinSizeReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sfc16_pkg::CfgPoly: poly_q <= cfg_data;
				sfc16_pkg::CfgSync: sync_q <= cfg_data[7:0];
				sfc16_pkg::CfgMinSize: min_size_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign advance = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
			last_s1 <= end_of_frame;
		end
	end

	sfc16_frame_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data      (byte_s1),
		.last      (last_s1),
		.poly      (poly_q),
		.sync_value(sync_q),
		.min_size  (min_size_q),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_status = result_q.status;
	assign frame_size = result_q.size;
	assign computed_crc = result_q.computed_crc;
	assign received_crc = result_q.received_crc;

endmodule

[hw/rtl/sfc16_crc_byte.sv]
`timescale 1ns / 1ps

module sfc16_crc_byte (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	input  logic [15:0] poly,
	output logic [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ poly;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

[hw/rtl/sfc16_frame_check.sv]
`timescale 1ns / 1ps

module sfc16_frame_check (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  logic [7:0]               data,
	input  logic                     last,
	input  logic [15:0]              poly,
	input  logic [7:0]               sync_value,
	input  logic [7:0]               min_size,
	output sfc16_pkg::frame_result_t result
);

	logic [sfc16_pkg::CountW-1:0] count_q;
	logic [sfc16_pkg::CountW-1:0] count_next;
	logic [15:0] crc_q;
	logic [15:0] crc_absorbed;
	logic [15:0] crc_next;
	logic [7:0] delay0_q;
	logic [7:0] delay1_q;
	logic [7:0] sync_q;
	logic [7:0] length_q;
	logic [7:0] sync_next;
	logic [7:0] length_next;
	logic [15:0] rx_crc;

	sfc16_crc_byte u_crc (
		.crc_in (crc_q),
		.data   (delay1_q),
		.poly   (poly),
		.crc_out(crc_absorbed)
	);

	assign count_next = (count_q == sfc16_pkg::CountMax) ? count_q
		: count_q + sfc16_pkg::CountW'(1);
	assign crc_next = (count_q >= sfc16_pkg::CountW'(2)) ? crc_absorbed : crc_q;
	assign sync_next = (count_q == '0) ? data : sync_q;
	assign length_next = (count_q == sfc16_pkg::CountW'(1)) ? data : length_q;
	assign rx_crc = {data, delay0_q};

	always_comb begin
		if (count_next < {1'b0, min_size}) begin
			result.status = sfc16_pkg::ST_TOO_SHORT;
		end else if (sync_next != sync_value) begin
			result.status = sfc16_pkg::ST_BAD_SYNC;
		end else if ({1'b0, length_next} != count_next) begin
			result.status = sfc16_pkg::ST_BAD_LENGTH;
		end else if (rx_crc != crc_next) begin
			result.status = sfc16_pkg::ST_BAD_CRC;
		end else begin
			result.status = sfc16_pkg::ST_OK;
		end
		result.size = count_next;
		result.computed_crc = crc_next;
		result.received_crc = rx_crc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q <= '0;
			delay0_q <= '0;
			delay1_q <= '0;
			sync_q <= '0;
			length_q <= '0;
		end else if (advance) begin
			if (last) begin
				count_q <= '0;
				crc_q <= '0;
				delay0_q <= '0;
				delay1_q <= '0;
				sync_q <= '0;
				length_q <= '0;
			end else begin
				count_q <= count_next;
				crc_q <= crc_next;
				delay0_q <= data;
				delay1_q <= delay0_q;
				sync_q <= sync_next;
				length_q <= length_next;
			end
		end
	end

endmodule

[hw/rtl/sfc16_checker.sv]
`timescale 1ns / 1ps

module sfc16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  frame_status,
	input logic [8:0]  frame_size,
	input logic [15:0] computed_crc,
	input logic [15:0] received_crc
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_status <= sfc16_pkg::ST_BAD_CRC)
		else $error("undefined frame status");

	// A frame reported as good must carry a matching checksum.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status == sfc16_pkg::ST_OK |-> computed_crc == received_crc)
		else $error("good status with mismatching checksum");

	// Frames of two bytes or fewer have no covered bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_size < 9'd3 |-> computed_crc == 16'h0000)
		else $error("checksum nonzero on a frame with no covered bytes");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status == sfc16_pkg::ST_OK |-> frame_size[8] == 1'b0)
		else $error("good status on an oversized frame");

endmodule

bind serial_frame_crc16_checker_top sfc16_checker u_sfc16_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.frame_status(frame_status),
	.frame_size  (frame_size),
	.computed_crc(computed_crc),
	.received_crc(received_crc)
);
